// File: src/somn_pkg.sv
package somn_pkg;

	localparam int MAX_FEATURES = 256;
	localparam int IDX_W = $clog2(MAX_FEATURES);
	localparam int VAL_W = 16;
	localparam int RATE_W = 16;
	localparam int SQ_W = 2 * VAL_W;
	localparam int SUM_W = 41;
	localparam int ACT_W = 40;

	localparam logic [RATE_W-1:0] RATE_RESET = 16'd6554;

	typedef enum logic [1:0] {
		OP_LOAD     = 2'd0,
		OP_ACTIVATE = 2'd1,
		OP_LEARN    = 2'd2
	} op_t;

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] addr;
		logic [VAL_W-1:0] data;
	} weight_wr_t;

endpackage

// File: src/somn_in_if.sv
interface somn_in_if;
	import somn_pkg::*;

	logic             valid;
	logic             ready;
	op_t              op;
	logic [IDX_W-1:0] feature_index;
	logic [VAL_W-1:0] feature_value;
	logic             last_element;

	modport source (
		output valid, op, feature_index, feature_value, last_element,
		input  ready
	);
	modport sink (
		input  valid, op, feature_index, feature_value, last_element,
		output ready
	);
endinterface

// File: src/somn_out_if.sv
interface somn_out_if;
	import somn_pkg::*;

	logic             valid;
	logic             ready;
	logic [ACT_W-1:0] activation;

	modport source (
		output valid, activation,
		input  ready
	);
	modport sink (
		input  valid, activation,
		output ready
	);
endinterface

// File: src/somn_cfg_if.sv
interface somn_cfg_if;
	import somn_pkg::*;

	logic              valid;
	logic              ready;
	logic [RATE_W-1:0] data;

	modport source (
		output valid, data,
		input  ready
	);
	modport sink (
		input  valid, data,
		output ready
	);
endinterface

// File: src/som_node_distance_and_learn.sv
// One self-organizing-map neuron holding up to 256 unsigned Q0.16 weights in a
// single-port-write, single-port-read memory. Each item transfer carries one
// feature element: load writes a weight, activate adds the squared difference
// to a running distance and, on the element marked last, delivers the squared
// Euclidean distance (saturated to 40 bits) and clears the sum, and learn moves
// the weight toward the value by the gain times the difference, rounded down.
// The block takes one item per clock cycle; the memory read, the one shared
// multiplier and the accumulate/write-back stage form a three-stage pipeline
// that ends in the output register. Back-to-back elements on the same feature
// are forwarded inside the pipeline. Input transfers stop only while a new
// distance waits on an output register that the sink has not yet taken. The
// user must write the gain through the configuration channel while the block
// is idle, which the block does not enforce; the gain resets to 6554.
module som_node_distance_and_learn (
	input  logic       clk,
	input  logic       arst_n,
	somn_cfg_if.sink   cfg,
	somn_in_if.sink    item,
	somn_out_if.source result
);
	import somn_pkg::*;

	logic [RATE_W-1:0] gain_q;
	logic              rd_en;
	logic [IDX_W-1:0]  rd_addr;
	logic [VAL_W-1:0]  rd_data;
	weight_wr_t        wr;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= RATE_RESET;
		end else if (cfg.valid) begin
			gain_q <= cfg.data;
		end
	end

	somn_weight_mem u_mem (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr      (wr)
	);

	somn_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item),
		.result     (result),
		.gain       (gain_q),
		.rd_en      (rd_en),
		.rd_addr    (rd_addr),
		.rd_data    (rd_data),
		.wr         (wr)
	);
endmodule

// File: src/somn_weight_mem.sv
module somn_weight_mem (
	input  logic                     clk,
	input  logic                     rd_en,
	input  logic [somn_pkg::IDX_W-1:0] rd_addr,
	output logic [somn_pkg::VAL_W-1:0] rd_data,
	input  somn_pkg::weight_wr_t     wr
);
	import somn_pkg::*;

	logic [VAL_W-1:0] mem [MAX_FEATURES];
	logic [VAL_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	// A read at the address being written returns the old word; the core
	// covers that case from its last-write register.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;
endmodule

// File: src/somn_core.sv
module somn_core (
	input  logic                      clk,
	input  logic                      arst_n,
	somn_in_if.sink                   item,
	somn_out_if.source                result,
	input  logic [somn_pkg::RATE_W-1:0] gain,
	output logic                      rd_en,
	output logic [somn_pkg::IDX_W-1:0]  rd_addr,
	input  logic [somn_pkg::VAL_W-1:0]  rd_data,
	output somn_pkg::weight_wr_t      wr
);
	import somn_pkg::*;

	// Stage 1: weight arrives from memory, difference and product.
	logic             valid_s1;
	op_t              op_s1;
	logic [IDX_W-1:0] addr_s1;
	logic [VAL_W-1:0] val_s1;
	logic             last_s1;

	// Stage 2: accumulate or write back.
	logic             valid_s2;
	op_t              op_s2;
	logic [IDX_W-1:0] addr_s2;
	logic             last_s2;
	logic [VAL_W-1:0] nw_s2;
	logic [SQ_W-1:0]  sq_s2;

	logic             lw_valid_q;
	logic [IDX_W-1:0] lw_addr_q;
	logic [VAL_W-1:0] lw_data_q;

	logic [SUM_W-1:0] sum_q;
	logic             out_valid_q;
	logic [ACT_W-1:0] act_q;

	logic             advance;
	logic             accept;
	logic             emit_s2;
	logic             write_s2;
	logic [VAL_W-1:0] w_s1;
	logic [VAL_W-1:0] abs_d;
	logic signed [VAL_W:0]     diff;
	logic signed [VAL_W:0]     mul_a;
	logic signed [VAL_W:0]     mul_b;
	logic signed [2*VAL_W+1:0] mul_p;
	logic signed [VAL_W+1:0]   step;
	logic signed [VAL_W+1:0]   nw_wide;
	logic [VAL_W-1:0] nw_s1;
	logic [SUM_W:0]   sum_add;
	logic [SUM_W-1:0] sum_sat;
	logic [ACT_W-1:0] act_sat;

	assign write_s2 = valid_s2 && (op_s2 == OP_LOAD || op_s2 == OP_LEARN);
	assign emit_s2  = valid_s2 && (op_s2 == OP_ACTIVATE) && last_s2;

	// The pipeline only halts when a new result meets a full output register that the sink is not taking.
	assign advance    = !(emit_s2 && out_valid_q && !result.ready);
	assign item.ready = advance;
	assign accept     = item.valid && advance;
	assign rd_en      = accept;
	assign rd_addr    = item.feature_index;

	// Newest weight for the stage 1 address: the write still in stage 2 wins,
	// then the word written at the edge of the memory read.
	always_comb begin
		if (write_s2 && addr_s2 == addr_s1) begin
			w_s1 = nw_s2;
		end else if (lw_valid_q && lw_addr_q == addr_s1) begin
			w_s1 = lw_data_q;
		end else begin
			w_s1 = rd_data;
		end
	end

	always_comb begin
		diff  = signed'({1'b0, val_s1}) - signed'({1'b0, w_s1});
		abs_d = (val_s1 >= w_s1) ? (val_s1 - w_s1) : (w_s1 - val_s1);
		if (op_s1 == OP_LEARN) begin
			mul_a = signed'({1'b0, gain});
			mul_b = diff;
		end else begin
			mul_a = signed'({1'b0, abs_d});
			mul_b = signed'({1'b0, abs_d});
		end
		mul_p = mul_a * mul_b;
		// Arithmetic shift floors the step; its size never exceeds the difference.
		step    = mul_p[2*VAL_W+1:VAL_W];
		nw_wide = signed'({2'b00, w_s1}) + step;
		if (op_s1 == OP_LOAD) begin
			nw_s1 = val_s1;
		end else begin
			nw_s1 = nw_wide[VAL_W-1:0];
		end
	end

	always_comb begin
		sum_add = {1'b0, sum_q} + {{(SUM_W + 1 - SQ_W){1'b0}}, sq_s2};
		sum_sat = sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];
		act_sat = sum_sat[SUM_W-1] ? {ACT_W{1'b1}} : sum_sat[ACT_W-1:0];
	end

	always_comb begin
		wr.en   = advance && write_s2;
		wr.addr = addr_s2;
		wr.data = nw_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1   <= item.op;
			addr_s1 <= item.feature_index;
			val_s1  <= item.feature_value;
			last_s1 <= item.last_element;
		end
		if (advance) begin
			op_s2   <= op_s1;
			addr_s2 <= addr_s1;
			last_s2 <= last_s1;
			nw_s2   <= nw_s1;
			sq_s2   <= mul_p[SQ_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lw_valid_q <= 1'b0;
		end else if (wr.en) begin
			lw_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr.en) begin
			lw_addr_q <= addr_s2;
			lw_data_q <= nw_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (advance && valid_s2 && op_s2 == OP_ACTIVATE) begin
			sum_q <= last_s2 ? '0 : sum_sat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && emit_s2) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit_s2) begin
			act_q <= act_sat;
		end
	end

	assign result.valid      = out_valid_q;
	assign result.activation = act_q;
endmodule
